// ----- rtl/lswc_pkg.sv -----
// shared constants, types and width helpers of the line segment window clipper
package lswc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int WIN_ONE        = 4096;
  localparam int OUT_W          = 14;
  localparam int OUT_TW         = 4 * OUT_W;
  localparam int LANES          = 4;
  localparam int MIN_CW         = 13;

  localparam logic [3:0] CODE_LEFT   = 4'h1;
  localparam logic [3:0] CODE_RIGHT  = 4'h2;
  localparam logic [3:0] CODE_BOTTOM = 4'h4;
  localparam logic [3:0] CODE_TOP    = 4'h8;

  // lane order of the crossing dividers
  localparam int LANE_START_X = 0;
  localparam int LANE_START_Y = 1;
  localparam int LANE_END_X   = 2;
  localparam int LANE_END_Y   = 3;

  typedef struct packed {
    logic [3:0] neg;
    logic [3:0] c_end;
    logic [3:0] c_start;
  } lswc_codes_t;

  // magnitude width of the crossing operands
  function automatic int mag_width(input int coord_bits);
    return ((coord_bits > MIN_CW) ? coord_bits : MIN_CW) + 1;
  endfunction

endpackage

// ----- rtl/line_segment_window_clipper.sv -----
// top level of the line segment window clipper: decode, divider cell chain, result stage
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------------------
//   in_     | in  | in_tvalid/in_tready  | tdata: start_x, start_y, end_x, end_y
//   out_    | out | out_tvalid/out_tready| tdata: clip_start_x/_y, clip_end_x/_y; tuser: visible
//
// one segment per clock sustained while out_tready is high; the core of the pipeline is
// the chain of restoring divider cells, one quotient bit per cell
// ahead of the chain: one decode stage and one multiply stage; behind it the result register
// reset (rst_n low, synchronous) clears only the per-stage valid bits
// a stalled output only holds the stages that are full up to it: in_tready stays high
// while any bubble is left in the chain, so new beats keep flowing in
module line_segment_window_clipper import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero fill to whole bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y from bit 0 up
  output logic [OUT_TW-1:0]                        out_tdata,
  // visible
  output logic                                     out_tuser
);

  localparam int MW = mag_width(COORD_BITS);
  localparam int PW = 2 * MW;
  localparam int QN = PW;              // divider cells, one per quotient bit
  localparam int NS = QN + 3;          // decode, multiply, cells, result

  // per-stage valid bits and the ready chain that lets bubbles fill
  logic [NS-1:0] vld_r, vld_nxt;
  logic [NS:0]   rdy;

  // cell chain taps
  logic [QN:0][3:0][COORD_BITS-1:0] ch_coord;
  lswc_codes_t                      ch_codes [QN+1];
  logic [QN:0][LANES-1:0][PW-1:0]   ch_prod, ch_q;
  logic [QN:0][LANES-1:0][MW-1:0]   ch_dm, ch_rm;

  logic                  visible;
  logic [3:0][OUT_W-1:0] clip;

  assign rdy[NS] = out_tready;
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_rdy
      // a stage may load when it is empty or its content moves on
      assign rdy[gi] = !vld_r[gi] || rdy[gi+1];
    end
  endgenerate

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NS-1];

  lswc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .en0     (rdy[0]),
    .en1     (rdy[1]),
    .start_x (in_tdata[COORD_BITS-1:0]),
    .start_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x   (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y   (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .coord_o (ch_coord[0]),
    .codes_o (ch_codes[0]),
    .prod_o  (ch_prod[0]),
    .dm_o    (ch_dm[0])
  );

  // division starts from an empty remainder and quotient
  assign ch_q[0]  = '0;
  assign ch_rm[0] = '0;

  generate
    for (gi = 0; gi < QN; gi++) begin : g_cell
      lswc_div_cell #(.COORD_BITS(COORD_BITS), .BIT(PW - 1 - gi)) u_cell (
        .clk     (clk),
        .en      (rdy[2+gi]),
        .coord_i (ch_coord[gi]),
        .codes_i (ch_codes[gi]),
        .prod_i  (ch_prod[gi]),
        .dm_i    (ch_dm[gi]),
        .q_i     (ch_q[gi]),
        .rm_i    (ch_rm[gi]),
        .coord_o (ch_coord[gi+1]),
        .codes_o (ch_codes[gi+1]),
        .prod_o  (ch_prod[gi+1]),
        .dm_o    (ch_dm[gi+1]),
        .q_o     (ch_q[gi+1]),
        .rm_o    (ch_rm[gi+1])
      );
    end
  endgenerate

  lswc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .en        (rdy[NS-1]),
    .coord_i   (ch_coord[QN]),
    .codes_i   (ch_codes[QN]),
    .dm_i      (ch_dm[QN]),
    .q_i       (ch_q[QN]),
    .rm_i      (ch_rm[QN]),
    .visible_o (visible),
    .clip_o    (clip)
  );

  assign out_tdata = clip;
  assign out_tuser = visible;

endmodule

// ----- rtl/lswc_front.sv -----
// outcode decode, crossing operand magnitudes and products, two register stages
module lswc_front import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   en0,
  input  logic                                   en1,
  input  logic [COORD_BITS-1:0]                  start_x,
  input  logic [COORD_BITS-1:0]                  start_y,
  input  logic [COORD_BITS-1:0]                  end_x,
  input  logic [COORD_BITS-1:0]                  end_y,
  output logic [3:0][COORD_BITS-1:0]             coord_o,
  output lswc_codes_t                            codes_o,
  output logic [LANES-1:0][2*mag_width(COORD_BITS)-1:0] prod_o,
  output logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   dm_o
);

  localparam int MW = mag_width(COORD_BITS);
  localparam int W  = MW + 1;
  localparam int PW = 2 * MW;
  localparam logic signed [W-1:0] POS = W'(WIN_ONE);
  localparam logic signed [W-1:0] NEG = -POS;

  logic signed [W-1:0] x1, y1, x2, y2, dx, dy;
  logic signed [W-1:0] ex1, ey1, ex2, ey2;
  logic signed [W-1:0] a_s [LANES];
  logic signed [W-1:0] b_s [LANES];
  logic signed [W-1:0] d_s [LANES];

  logic [3:0][COORD_BITS-1:0] coord0_r, coord0_nxt, coord1_r;
  lswc_codes_t                codes0_r, codes0_nxt, codes1_r;
  logic [LANES-1:0][MW-1:0]   am_r, am_nxt, bm_r, bm_nxt, dm0_r, dm0_nxt, dm1_r;
  logic [LANES-1:0][PW-1:0]   prod_r, prod_nxt;

  function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y);
    logic [3:0] c;
    c = '0;
    if (x < NEG) c = c | CODE_LEFT;
    if (x > POS) c = c | CODE_RIGHT;
    if (y < NEG) c = c | CODE_BOTTOM;
    if (y > POS) c = c | CODE_TOP;
    return c;
  endfunction

  function automatic logic signed [W-1:0] edge_x(input logic [3:0] c);
    logic signed [W-1:0] e;
    e = '0;
    if ((c & CODE_LEFT) != '0) e = NEG;
    if ((c & CODE_RIGHT) != '0) e = POS;
    return e;
  endfunction

  function automatic logic signed [W-1:0] edge_y(input logic [3:0] c);
    logic signed [W-1:0] e;
    e = '0;
    if ((c & CODE_BOTTOM) != '0) e = NEG;
    if ((c & CODE_TOP) != '0) e = POS;
    return e;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [W-1:0] v);
    logic signed [W-1:0] n;
    n = -v;
    return v[W-1] ? n[MW-1:0] : v[MW-1:0];
  endfunction

  always_comb begin
    x1 = W'($signed(start_x));
    y1 = W'($signed(start_y));
    x2 = W'($signed(end_x));
    y2 = W'($signed(end_y));
    dx = x2 - x1;
    dy = y2 - y1;
    codes0_nxt.c_start = outcode(x1, y1);
    codes0_nxt.c_end   = outcode(x2, y2);
    ex1 = edge_x(codes0_nxt.c_start);
    ey1 = edge_y(codes0_nxt.c_start);
    ex2 = edge_x(codes0_nxt.c_end);
    ey2 = edge_y(codes0_nxt.c_end);
    // x crossings step along dx over dy, y crossings along dy over dx
    a_s[LANE_START_X] = ey1 - y1;  b_s[LANE_START_X] = dx;  d_s[LANE_START_X] = dy;
    a_s[LANE_START_Y] = ex1 - x1;  b_s[LANE_START_Y] = dy;  d_s[LANE_START_Y] = dx;
    a_s[LANE_END_X]   = ey2 - y2;  b_s[LANE_END_X]   = dx;  d_s[LANE_END_X]   = dy;
    a_s[LANE_END_Y]   = ex2 - x2;  b_s[LANE_END_Y]   = dy;  d_s[LANE_END_Y]   = dx;
    for (int l = 0; l < LANES; l++) begin
      am_nxt[l]  = mag(a_s[l]);
      bm_nxt[l]  = mag(b_s[l]);
      dm0_nxt[l] = mag(d_s[l]);
      codes0_nxt.neg[l] = a_s[l][W-1] ^ b_s[l][W-1] ^ d_s[l][W-1];
    end
    coord0_nxt = {end_y, end_x, start_y, start_x};
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod_nxt[l] = am_r[l] * bm_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      coord0_r <= coord0_nxt;
      codes0_r <= codes0_nxt;
      am_r     <= am_nxt;
      bm_r     <= bm_nxt;
      dm0_r    <= dm0_nxt;
    end
    if (en1) begin
      coord1_r <= coord0_r;
      codes1_r <= codes0_r;
      prod_r   <= prod_nxt;
      dm1_r    <= dm0_r;
    end
  end

  assign coord_o = coord1_r;
  assign codes_o = codes1_r;
  assign prod_o  = prod_r;
  assign dm_o    = dm1_r;

endmodule

// ----- rtl/lswc_div_cell.sv -----
// one restoring division step for all four crossing lanes, plus segment payload
module lswc_div_cell import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int BIT        = 0
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [3:0][COORD_BITS-1:0]                    coord_i,
  input  lswc_codes_t                                   codes_i,
  input  logic [LANES-1:0][2*mag_width(COORD_BITS)-1:0] prod_i,
  input  logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   dm_i,
  input  logic [LANES-1:0][2*mag_width(COORD_BITS)-1:0] q_i,
  input  logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   rm_i,
  output logic [3:0][COORD_BITS-1:0]                    coord_o,
  output lswc_codes_t                                   codes_o,
  output logic [LANES-1:0][2*mag_width(COORD_BITS)-1:0] prod_o,
  output logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   dm_o,
  output logic [LANES-1:0][2*mag_width(COORD_BITS)-1:0] q_o,
  output logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   rm_o
);

  localparam int MW = mag_width(COORD_BITS);
  localparam int PW = 2 * MW;

  logic [3:0][COORD_BITS-1:0] coord_r;
  lswc_codes_t                codes_r;
  logic [LANES-1:0][PW-1:0]   prod_r, q_r, q_nxt;
  logic [LANES-1:0][MW-1:0]   dm_r, rm_r, rm_nxt;
  logic [MW:0]                rt   [LANES];
  logic [MW:0]                diff [LANES];
  logic                       ge   [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rt[l]     = {rm_i[l], prod_i[l][BIT]};
      diff[l]   = rt[l] - {1'b0, dm_i[l]};
      ge[l]     = rt[l] >= {1'b0, dm_i[l]};
      rm_nxt[l] = ge[l] ? diff[l][MW-1:0] : rt[l][MW-1:0];
      q_nxt[l]  = {q_i[l][PW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_i;
      codes_r <= codes_i;
      prod_r  <= prod_i;
      dm_r    <= dm_i;
      q_r     <= q_nxt;
      rm_r    <= rm_nxt;
    end
  end

  assign coord_o = coord_r;
  assign codes_o = codes_r;
  assign prod_o  = prod_r;
  assign dm_o    = dm_r;
  assign q_o     = q_r;
  assign rm_o    = rm_r;

endmodule

// ----- rtl/lswc_back.sv -----
// quotient rounding, crossing add, reject test and clamp into the result register
module lswc_back import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [3:0][COORD_BITS-1:0]                    coord_i,
  input  lswc_codes_t                                   codes_i,
  input  logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   dm_i,
  input  logic [LANES-1:0][2*mag_width(COORD_BITS)-1:0] q_i,
  input  logic [LANES-1:0][mag_width(COORD_BITS)-1:0]   rm_i,
  output logic                                          visible_o,
  output logic [3:0][OUT_W-1:0]                         clip_o
);

  localparam int MW = mag_width(COORD_BITS);
  localparam int PW = 2 * MW;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] POS = SW'(WIN_ONE);
  localparam logic signed [SW-1:0] NEG = -POS;

  logic                     rnd [LANES];
  logic [PW:0]              qm  [LANES];
  logic signed [SW-1:0]     sq  [LANES];
  logic signed [SW-1:0]     cr  [LANES];
  logic signed [SW-1:0]     pe  [LANES];
  logic signed [SW-1:0]     sx, sy, tx, ty;
  logic                     reject;
  logic                     visible_r, visible_nxt;
  logic [3:0][OUT_W-1:0]    clip_r, clip_nxt;

  function automatic logic signed [SW-1:0] edge_x(input logic [3:0] c);
    logic signed [SW-1:0] e;
    e = '0;
    if ((c & CODE_LEFT) != '0) e = NEG;
    if ((c & CODE_RIGHT) != '0) e = POS;
    return e;
  endfunction

  function automatic logic signed [SW-1:0] edge_y(input logic [3:0] c);
    logic signed [SW-1:0] e;
    e = '0;
    if ((c & CODE_BOTTOM) != '0) e = NEG;
    if ((c & CODE_TOP) != '0) e = POS;
    return e;
  endfunction

  function automatic logic outside(input logic signed [SW-1:0] v);
    return (v < NEG) || (v > POS);
  endfunction

  function automatic logic [OUT_W-1:0] clampw(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v < NEG) c = NEG;
    if (v > POS) c = POS;
    return c[OUT_W-1:0];
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // round half away from zero on the magnitude, zero divisor gives zero
      rnd[l] = {rm_i[l], 1'b0} >= {1'b0, dm_i[l]};
      qm[l]  = (dm_i[l] == '0) ? '0 : ({1'b0, q_i[l]} + (PW + 1)'(rnd[l]));
      sq[l]  = codes_i.neg[l] ? -$signed(SW'(qm[l])) : $signed(SW'(qm[l]));
      pe[l]  = SW'($signed(coord_i[l]));
      cr[l]  = pe[l] + sq[l];
    end

    if (codes_i.c_start == '0) begin
      sx = pe[LANE_START_X];
      sy = pe[LANE_START_Y];
    end else begin
      sx = ((codes_i.c_start & (CODE_TOP | CODE_BOTTOM)) != '0) ?
           cr[LANE_START_X] : edge_x(codes_i.c_start);
      sy = ((codes_i.c_start & (CODE_LEFT | CODE_RIGHT)) != '0) ?
           cr[LANE_START_Y] : edge_y(codes_i.c_start);
    end

    if (codes_i.c_end == '0) begin
      tx = pe[LANE_END_X];
      ty = pe[LANE_END_Y];
    end else begin
      tx = ((codes_i.c_end & (CODE_TOP | CODE_BOTTOM)) != '0) ?
           cr[LANE_END_X] : edge_x(codes_i.c_end);
      ty = ((codes_i.c_end & (CODE_LEFT | CODE_RIGHT)) != '0) ?
           cr[LANE_END_Y] : edge_y(codes_i.c_end);
    end

    reject = ((codes_i.c_start & codes_i.c_end) != '0) ||
             ((codes_i.c_start != '0) && outside(sx) && outside(sy));

    visible_nxt = !reject;
    if (reject) begin
      clip_nxt = '0;
    end else begin
      clip_nxt = {clampw(ty), clampw(tx), clampw(sy), clampw(sx)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible_r <= visible_nxt;
      clip_r    <= clip_nxt;
    end
  end

  assign visible_o = visible_r;
  assign clip_o    = clip_r;

endmodule

// ----- rtl/lswc_checker.sv -----
// port-level checks of the line segment window clipper and their bind
module lswc_checker import lswc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [OUT_TW-1:0]                 out_tdata,
  input logic                              out_tuser
);

  localparam logic signed [OUT_W-1:0] POS = OUT_W'(WIN_ONE);
  localparam logic signed [OUT_W-1:0] NEG = -POS;

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tdata))
    else $error("accepted segment beat carries unknown bits");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected segment carries coordinates");

  a_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      $signed(out_tdata[OUT_W-1:0]) >= NEG && $signed(out_tdata[OUT_W-1:0]) <= POS &&
      $signed(out_tdata[2*OUT_W-1:OUT_W]) >= NEG &&
      $signed(out_tdata[2*OUT_W-1:OUT_W]) <= POS &&
      $signed(out_tdata[3*OUT_W-1:2*OUT_W]) >= NEG &&
      $signed(out_tdata[3*OUT_W-1:2*OUT_W]) <= POS &&
      $signed(out_tdata[4*OUT_W-1:3*OUT_W]) >= NEG &&
      $signed(out_tdata[4*OUT_W-1:3*OUT_W]) <= POS)
    else $error("clipped endpoint outside the window");

endmodule

bind line_segment_window_clipper lswc_checker #(.COORD_BITS(COORD_BITS)) u_lswc_checker (.*);
